FILE: sv/rgbx_pkg.sv
// Shared types, constants and channel widening function for the RGB16 expand/scale unit.
// No dependencies.
`timescale 1ns / 1ps
package rgbx_pkg;

  localparam int unsigned PIX_W    = 16;
  localparam int unsigned EXP_W    = 10;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned FACTOR_W = 9;
  localparam int unsigned PROD_W   = EXP_W + FACTOR_W;
  localparam int unsigned FLO_W    = 4;
  localparam int unsigned FHI_W    = FACTOR_W - FLO_W;
  localparam int unsigned PLO_W    = EXP_W + FLO_W;
  localparam int unsigned PHI_W    = EXP_W + FHI_W;
  localparam int unsigned NUM_CH   = 3;
  localparam int unsigned OUT_W    = EXP_W * NUM_CH;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 9;

  localparam logic [FACTOR_W-1:0] FACTOR_MAX = 9'd256;
  localparam logic [3:0] WIDTH_MIN = 4'd5;
  localparam logic [3:0] WIDTH_MAX = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_FACTOR   = 3'd0,
    REG_RED_POSITION   = 3'd1,
    REG_RED_WIDTH      = 3'd2,
    REG_GREEN_POSITION = 3'd3,
    REG_GREEN_WIDTH    = 3'd4,
    REG_BLUE_POSITION  = 3'd5,
    REG_BLUE_WIDTH     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [3:0] pos;
    logic [3:0] width;
  } chan_cfg_t;

  typedef struct packed {
    logic [PHI_W-1:0] hi;
    logic [PLO_W-1:0] lo;
  } part_prod_t;

  typedef chan_cfg_t [NUM_CH-1:0] chan_cfg_arr_t;
  typedef logic [NUM_CH-1:0][EXP_W-1:0] chan_exp_arr_t;
  typedef part_prod_t [NUM_CH-1:0] chan_prod_arr_t;

  function automatic logic [3:0] sat_width(input logic [3:0] w);
    logic [3:0] r;
    if (w < WIDTH_MIN) begin
      r = WIDTH_MIN;
    end else if (w > WIDTH_MAX) begin
      r = WIDTH_MAX;
    end else begin
      r = w;
    end
    return r;
  endfunction

  // Extract the channel and replicate its top bits below it to fill 10 bits.
  function automatic logic [EXP_W-1:0] extract_widen(input logic [PIX_W-1:0] pix,
                                                      input chan_cfg_t cfg);
    logic [PIX_W-1:0] sh;
    logic [7:0] v;
    logic [EXP_W-1:0] r;
    sh = pix >> cfg.pos;
    v  = sh[7:0];
    case (sat_width(cfg.width))
      4'd5:    r = {v[4:0], v[4:0]};
      4'd6:    r = {v[5:0], v[5:2]};
      4'd7:    r = {v[6:0], v[6:4]};
      default: r = {v[7:0], v[7:6]};
    endcase
    return r;
  endfunction

endpackage

FILE: sv/rgbx_unpack_stage.sv
// Stage 1: extract each channel from the pixel and widen it to 10 bits.
// Depends on rgbx_pkg.
`timescale 1ns / 1ps
module rgbx_unpack_stage import rgbx_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  chan_cfg_arr_t       chan_cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PIX_W-1:0]    in_pixel,
  output logic                out_valid,
  input  logic                out_ready,
  output chan_exp_arr_t       out_exp
);

  logic          valid_r;
  chan_exp_arr_t exp_r;
  chan_exp_arr_t exp_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      exp_nxt[i] = extract_widen(in_pixel, chan_cfg[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      exp_r <= exp_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_exp   = exp_r;

endmodule

FILE: sv/rgbx_scale_stage.sv
// Stage 2: form the low and high partial products of each widened channel and the
// saturated 1.8 scale factor. Depends on rgbx_pkg.
`timescale 1ns / 1ps
module rgbx_scale_stage import rgbx_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [FACTOR_W-1:0] factor,
  input  logic                in_valid,
  output logic                in_ready,
  input  chan_exp_arr_t       in_exp,
  output logic                out_valid,
  input  logic                out_ready,
  output chan_prod_arr_t      out_prod
);

  logic           valid_r;
  chan_prod_arr_t prod_r;
  chan_prod_arr_t prod_nxt;
  logic [FACTOR_W-1:0] factor_sat;

  assign in_ready   = !valid_r || out_ready;
  assign factor_sat = (factor > FACTOR_MAX) ? FACTOR_MAX : factor;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      prod_nxt[i].lo = PLO_W'(in_exp[i]) * PLO_W'(factor_sat[FLO_W-1:0]);
      prod_nxt[i].hi = PHI_W'(in_exp[i]) * PHI_W'(factor_sat[FACTOR_W-1:FLO_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_prod  = prod_r;

endmodule

FILE: sv/rgbx_pack_stage.sv
// Stage 3: sum the partial products, drop the fraction bits and pack the channels
// into the output register. Depends on rgbx_pkg.
`timescale 1ns / 1ps
module rgbx_pack_stage import rgbx_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  chan_prod_arr_t   in_prod,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_word
);

  logic                          valid_r;
  logic [OUT_W-1:0]              word_r;
  logic [OUT_W-1:0]              word_nxt;
  logic [NUM_CH-1:0][PROD_W-1:0] sum;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      sum[i] = {in_prod[i].hi, {FLO_W{1'b0}}} + PROD_W'(in_prod[i].lo);
      word_nxt[i*EXP_W +: EXP_W] = sum[i][FRAC_W +: EXP_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

FILE: sv/rgb16_expand_and_scale_unit.sv
// Top level of the RGB16 expand/scale unit: configuration registers and three-stage pipeline.
// Depends on rgbx_pkg, rgbx_unpack_stage, rgbx_scale_stage, rgbx_pack_stage.
//
//   channel | ports                               | beat
//   --------+-------------------------------------+------------------------------
//   input   | in_valid, in_ready, in_pixel        | one 16-bit packed pixel
//   output  | out_valid, out_ready, out_scaled_word | one 30-bit scaled RGB word
//   config  | cfg_we, cfg_index, cfg_data         | one register write, no wait
//
// One beat per cycle while out_ready is high; the stages are unpack, partial products and sum.
// Each stage holds a valid bit; a stage refills as soon as its beat moves on.
// out_ready low stalls the pipe from the back; bubbles still collapse.
// Synchronous reset empties all stages and loads the default register values.
`timescale 1ns / 1ps
module rgb16_expand_and_scale_unit import rgbx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_pixel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_W-1:0]     out_scaled_word
);

  logic [FACTOR_W-1:0] factor_r;
  chan_cfg_arr_t       chan_cfg_r;

  logic           s1_valid;
  logic           s1_ready;
  chan_exp_arr_t  s1_exp;
  logic           s2_valid;
  logic           s2_ready;
  chan_prod_arr_t s2_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r         <= 9'd0;
      chan_cfg_r[0]    <= '{pos: 4'd11, width: 4'd5};
      chan_cfg_r[1]    <= '{pos: 4'd5,  width: 4'd6};
      chan_cfg_r[2]    <= '{pos: 4'd0,  width: 4'd5};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE_FACTOR:   factor_r            <= cfg_data;
        REG_RED_POSITION:   chan_cfg_r[0].pos   <= cfg_data[3:0];
        REG_RED_WIDTH:      chan_cfg_r[0].width <= cfg_data[3:0];
        REG_GREEN_POSITION: chan_cfg_r[1].pos   <= cfg_data[3:0];
        REG_GREEN_WIDTH:    chan_cfg_r[1].width <= cfg_data[3:0];
        REG_BLUE_POSITION:  chan_cfg_r[2].pos   <= cfg_data[3:0];
        REG_BLUE_WIDTH:     chan_cfg_r[2].width <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  rgbx_unpack_stage u_unpack (
    .clk       (clk),
    .rst_n     (rst_n),
    .chan_cfg  (chan_cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pixel  (in_pixel),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_exp   (s1_exp)
  );

  rgbx_scale_stage u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .factor    (factor_r),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_exp    (s1_exp),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_prod  (s2_prod)
  );

  rgbx_pack_stage u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_prod   (s2_prod),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_scaled_word)
  );

endmodule

FILE: sv/rgbx_checker.sv
// Port-level checks for the RGB16 expand/scale unit, bound to the top level.
// Depends on rgbx_pkg and rgb16_expand_and_scale_unit.
`timescale 1ns / 1ps
module rgbx_checker import rgbx_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] out_scaled_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_scaled_word))
    else $error("output beat dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output side is ready");

  a_empty_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no output beat pending");

endmodule

bind rgb16_expand_and_scale_unit rgbx_checker u_rgbx_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_scaled_word (out_scaled_word)
);

FILE: verif/rgb16_expand_and_scale_unit_tb.sv
// Self-checking bench for rgb16_expand_and_scale_unit: a directed table, then random phases
// that rewrite every register. Each result word is checked against a table word or a
// local channel model. Depends on rgbx_pkg and the unit RTL.
`timescale 1ns / 1ps
module rgb16_expand_and_scale_unit_tb;
  import rgbx_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_IDX = 3'd7;
  localparam int                   DIR_ROWS       = 37;
  localparam int                   PHASES         = 10;
  localparam int                   PHASE_BEATS    = 85;
  localparam int                   IDLE_PCT       = 36;

  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
    logic [PIX_W-1:0]     pixel;
    bit                   known;
    logic [OUT_W-1:0]     word;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel  = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_W-1:0]     out_scaled_word;

  logic [FACTOR_W-1:0]  scale_reg;
  logic [3:0]           chan_pos [NUM_CH];
  logic [3:0]           chan_wid [NUM_CH];
  logic [OUT_W-1:0]     expected_words [$];
  logic [OUT_W-1:0]     want_word;
  int                   error_count = 0;
  bit                   no_stall    = 1'b0;

  dir_row_t dir_plan [DIR_ROWS] = '{
    '{1'b0, REG_SCALE_FACTOR,   9'd0,     16'hFFFF, 1'b1, 30'h0},
    '{1'b0, REG_SCALE_FACTOR,   9'd0,     16'h1234, 1'b1, 30'h0},
    '{1'b1, REG_SCALE_FACTOR,   9'd256,   16'h0000, 1'b0, 30'h0},
    '{1'b0, REG_SCALE_FACTOR,   9'd0,     16'hFFFF, 1'b1, 30'h3FFFFFFF},
    '{1'b0, REG_SCALE_FACTOR,   9'd0,     16'h0000, 1'b1, 30'h0},
    '{1'b0, REG_SCALE_FACTOR,   9'd0,     16'hF800, 1'b1, 30'h000003FF},
    '{1'b0, REG_SCALE_FACTOR,   9'd0,     16'h07E0, 1'b1, 30'h000FFC00},
    '{1'b0, REG_SCALE_FACTOR,   9'd0,     16'h001F, 1'b1, 30'h3FF00000},
    '{1'b1, REG_SCALE_FACTOR,   9'd128,   16'h0000, 1'b0, 30'h0},
    '{1'b0, REG_SCALE_FACTOR,   9'd0,     16'hFFFF, 1'b1, 30'h1FF7FDFF},
    '{1'b0, REG_SCALE_FACTOR,   9'd0,     16'h8410, 1'b0, 30'h0},
    '{1'b1, REG_SCALE_FACTOR,   9'd511,   16'h0000, 1'b0, 30'h0},
    '{1'b0, REG_SCALE_FACTOR,   9'd0,     16'hFFFF, 1'b1, 30'h3FFFFFFF},
    '{1'b1, REG_SCALE_FACTOR,   9'd257,   16'h0000, 1'b0, 30'h0},
    '{1'b0, REG_SCALE_FACTOR,   9'd0,     16'hFFFF, 1'b1, 30'h3FFFFFFF},
    '{1'b1, REG_UNUSED_IDX,     9'd0,     16'h0000, 1'b0, 30'h0},
    '{1'b0, REG_SCALE_FACTOR,   9'd0,     16'hFFFF, 1'b1, 30'h3FFFFFFF},
    '{1'b1, REG_SCALE_FACTOR,   9'd1,     16'h0000, 1'b0, 30'h0},
    '{1'b0, REG_SCALE_FACTOR,   9'd0,     16'hFFFF, 1'b1, 30'h00300C03},
    '{1'b1, REG_SCALE_FACTOR,   9'd256,   16'h0000, 1'b0, 30'h0},
    '{1'b1, REG_RED_WIDTH,      9'd0,     16'h0000, 1'b0, 30'h0},
    '{1'b1, REG_GREEN_WIDTH,    9'd15,    16'h0000, 1'b0, 30'h0},
    '{1'b1, REG_BLUE_WIDTH,     9'd8,     16'h0000, 1'b0, 30'h0},
    '{1'b1, REG_RED_POSITION,   9'd15,    16'h0000, 1'b0, 30'h0},
    '{1'b1, REG_GREEN_POSITION, 9'd12,    16'h0000, 1'b0, 30'h0},
    '{1'b1, REG_BLUE_POSITION,  9'h1F3,   16'h0000, 1'b0, 30'h0},
    '{1'b0, REG_SCALE_FACTOR,   9'd0,     16'hFFFF, 1'b0, 30'h0},
    '{1'b0, REG_SCALE_FACTOR,   9'd0,     16'hAAAA, 1'b0, 30'h0},
    '{1'b0, REG_SCALE_FACTOR,   9'd0,     16'h5555, 1'b0, 30'h0},
    '{1'b1, REG_RED_WIDTH,      9'd7,     16'h0000, 1'b0, 30'h0},
    '{1'b1, REG_RED_POSITION,   9'd0,     16'h0000, 1'b0, 30'h0},
    '{1'b1, REG_GREEN_POSITION, 9'd8,     16'h0000, 1'b0, 30'h0},
    '{1'b1, REG_BLUE_WIDTH,     9'd6,     16'h0000, 1'b0, 30'h0},
    '{1'b1, REG_BLUE_POSITION,  9'd10,    16'h0000, 1'b0, 30'h0},
    '{1'b0, REG_SCALE_FACTOR,   9'd0,     16'h8001, 1'b0, 30'h0},
    '{1'b0, REG_SCALE_FACTOR,   9'd0,     16'h7FFE, 1'b0, 30'h0},
    '{1'b0, REG_SCALE_FACTOR,   9'd0,     16'hC3A5, 1'b0, 30'h0}
  };

  rgb16_expand_and_scale_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_scaled_word(out_scaled_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAIL rgb16_expand_and_scale_unit");
    $finish;
  end

  // Widen one channel: channel bits on top, its top bits repeated below.
  function automatic logic [EXP_W-1:0] expand_chan(input logic [PIX_W-1:0] pix,
                                                   input logic [3:0] pos,
                                                   input logic [3:0] wid);
    int unsigned w;
    int unsigned fill;
    int unsigned bits;
    w    = 32'((wid < WIDTH_MIN) ? WIDTH_MIN : (wid > WIDTH_MAX) ? WIDTH_MAX : wid);
    fill = EXP_W - w;
    bits = (32'(pix) >> pos) & ((32'd1 << w) - 1);
    return EXP_W'((bits << fill) | (bits >> (w - fill)));
  endfunction

  function automatic logic [OUT_W-1:0] scaled_pixel_word(input logic [PIX_W-1:0] pix);
    int unsigned      factor;
    int unsigned      chan;
    logic [OUT_W-1:0] word;
    factor = 32'((scale_reg > FACTOR_MAX) ? FACTOR_MAX : scale_reg);
    word   = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      chan = (32'(expand_chan(pix, chan_pos[c], chan_wid[c])) * factor) >> FRAC_W;
      word[c*EXP_W +: EXP_W] = chan[EXP_W-1:0];
    end
    return word;
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_reg_value(input int r, input int ph);
    logic [CFG_DAT_W-1:0] v;
    bit                   extreme_lo;
    bit                   extreme_hi;
    extreme_lo = (ph % 5 == 0);
    extreme_hi = (ph % 5 == 1);
    case (r)
      REG_SCALE_FACTOR: begin
        if (extreme_lo) v = '0;
        else if (extreme_hi) v = FACTOR_MAX;
        else if (ph % 5 == 2) v = CFG_DAT_W'($urandom_range(511, 257));
        else v = CFG_DAT_W'($urandom_range(256));
      end
      REG_RED_POSITION, REG_GREEN_POSITION, REG_BLUE_POSITION: begin
        if (extreme_lo) v = '0;
        else if (extreme_hi) v = CFG_DAT_W'(11);
        else if ($urandom_range(3) == 0) v = CFG_DAT_W'($urandom_range(511));
        else v = CFG_DAT_W'($urandom_range(11));
      end
      default: begin
        if (extreme_lo) v = CFG_DAT_W'(WIDTH_MIN);
        else if (extreme_hi) v = CFG_DAT_W'(WIDTH_MAX);
        else if ($urandom_range(3) == 0) v = CFG_DAT_W'($urandom_range(511));
        else v = CFG_DAT_W'($urandom_range(WIDTH_MAX, WIDTH_MIN));
      end
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SCALE_FACTOR:   scale_reg   = data;
      REG_RED_POSITION:   chan_pos[0] = data[3:0];
      REG_RED_WIDTH:      chan_wid[0] = data[3:0];
      REG_GREEN_POSITION: chan_pos[1] = data[3:0];
      REG_GREEN_WIDTH:    chan_wid[1] = data[3:0];
      REG_BLUE_POSITION:  chan_pos[2] = data[3:0];
      REG_BLUE_WIDTH:     chan_wid[2] = data[3:0];
      default: ;
    endcase
  endtask

  // Drop valid and hold until every expected word has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    cfg_we   <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit known,
                            input logic [OUT_W-1:0] word);
    cfg_we <= 1'b0;
    while (!no_stall && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    do @(posedge clk); while (!in_ready);
    expected_words.push_back(known ? word : scaled_pixel_word(pix));
  endtask

  always @(posedge clk) begin
    out_ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("scaled_word: unexpected beat, got %h", out_scaled_word);
        error_count++;
      end else begin
        want_word = expected_words.pop_front();
        if (out_scaled_word !== want_word) begin
          $error("scaled_word: expected %h, got %h", want_word, out_scaled_word);
          error_count++;
        end
      end
    end
  end

  initial begin
    logic [PIX_W-1:0] pix;
    scale_reg   = '0;
    chan_pos[0] = 4'd11;
    chan_wid[0] = 4'd5;
    chan_pos[1] = 4'd5;
    chan_wid[1] = 4'd6;
    chan_pos[2] = 4'd0;
    chan_wid[2] = 4'd5;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_plan[i]) begin
      if (dir_plan[i].is_write) begin
        wait_idle();
        write_reg(dir_plan[i].idx, dir_plan[i].data);
      end else begin
        send_pixel(dir_plan[i].pixel, dir_plan[i].known, dir_plan[i].word);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      no_stall = (ph == 4 || ph == 5);
      for (int r = REG_SCALE_FACTOR; r <= REG_BLUE_WIDTH; r++) begin
        write_reg(r[CFG_IDX_W-1:0], pick_reg_value(r, ph));
      end
      write_reg(REG_UNUSED_IDX, CFG_DAT_W'($urandom_range(511)));
      for (int n = 0; n < PHASE_BEATS; n++) begin
        case ($urandom_range(15))
          0:       pix = '0;
          1:       pix = '1;
          default: pix = PIX_W'($urandom_range(65535));
        endcase
        send_pixel(pix, 1'b0, '0);
      end
    end
    no_stall = 1'b0;

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS rgb16_expand_and_scale_unit");
    end else begin
      $display("FAIL rgb16_expand_and_scale_unit");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/rgbx_pkg.sv
sv/rgbx_unpack_stage.sv
sv/rgbx_scale_stage.sv
sv/rgbx_pack_stage.sv
sv/rgb16_expand_and_scale_unit.sv
sv/rgbx_checker.sv
verif/rgb16_expand_and_scale_unit_tb.sv
